[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// implication checked during reset too
`define ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

[sv/xdiv_pkg.sv]
// ---------------------------------------------------------------------------
// xdiv_pkg
// Types, constants and helpers of the double-width divider.
// ---------------------------------------------------------------------------
package xdiv_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned NUM_W   = 2 * WORD_W;
  localparam int unsigned STEPS   = NUM_W;

  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  typedef struct packed {
    logic              zero;
    logic              sa;
    logic              sb;
    logic [1:0]        size;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] d;
    logic [NUM_W-1:0]  num;
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] quo;
  } work_t;

  function automatic logic [WORD_W-1:0] size_mask(input logic [1:0] size);
    logic [WORD_W-1:0] m;
    unique case (size)
      SIZE_8:  m = 64'h0000_0000_0000_00ff;
      SIZE_16: m = 64'h0000_0000_0000_ffff;
      SIZE_32: m = 64'h0000_0000_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

endpackage

[sv/xdiv_prep.sv]
// ---------------------------------------------------------------------------
// xdiv_prep
// Join the dividend halves, take magnitudes and detect a zero divisor.
// ---------------------------------------------------------------------------
module xdiv_prep (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic                  is_signed,
  input  logic [1:0]            size,
  input  logic [63:0]           dividend_low,
  input  logic [63:0]           dividend_high,
  input  logic [63:0]           divisor,
  output logic                  out_valid,
  output xdiv_pkg::work_t       out_work
);
  import xdiv_pkg::*;

  logic [WORD_W-1:0] mask, lo, hi, d, dneg;
  logic [NUM_W-1:0]  num, mag;
  logic              sa, sb;
  work_t             work_next;

  always_comb begin
    mask = size_mask(size);
    lo   = dividend_low & mask;
    hi   = dividend_high & mask;
    d    = divisor & mask;
    unique case (size)
      SIZE_8: begin
        sa  = is_signed & hi[7];
        sb  = is_signed & d[7];
        num = {{112{sa}}, hi[7:0], lo[7:0]};
      end
      SIZE_16: begin
        sa  = is_signed & hi[15];
        sb  = is_signed & d[15];
        num = {{96{sa}}, hi[15:0], lo[15:0]};
      end
      SIZE_32: begin
        sa  = is_signed & hi[31];
        sb  = is_signed & d[31];
        num = {{64{sa}}, hi[31:0], lo[31:0]};
      end
      default: begin
        sa  = is_signed & hi[63];
        sb  = is_signed & d[63];
        num = {hi, lo};
      end
    endcase
    mag  = sa ? (~num + 128'd1) : num;
    dneg = (~d + 64'd1) & mask;
    work_next.zero = (d == '0);
    work_next.sa   = sa;
    work_next.sb   = sb;
    work_next.size = size;
    work_next.lo   = lo;
    work_next.d    = sb ? dneg : d;
    work_next.num  = mag;
    work_next.rem  = '0;
    work_next.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_work <= work_next;
    end
  end

endmodule

[sv/xdiv_step.sv]
// ---------------------------------------------------------------------------
// xdiv_step
// One restoring division step: shift in a dividend bit, trial subtract.
// ---------------------------------------------------------------------------
module xdiv_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  xdiv_pkg::work_t in_work,
  output logic            out_valid,
  output xdiv_pkg::work_t out_work
);
  import xdiv_pkg::*;

  logic [WORD_W:0]   trial, diff;
  logic              take;
  work_t             work_next;

  always_comb begin
    trial = {in_work.rem, in_work.num[NUM_W-1]};
    diff  = trial - {1'b0, in_work.d};
    take  = (trial >= {1'b0, in_work.d});
    work_next     = in_work;
    work_next.num = {in_work.num[NUM_W-2:0], 1'b0};
    work_next.rem = take ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
    work_next.quo = {in_work.quo[WORD_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_work <= work_next;
    end
  end

endmodule

[sv/xdiv_post.sv]
// ---------------------------------------------------------------------------
// xdiv_post
// Restore signs, cut to operand size and apply the zero-divisor result.
// ---------------------------------------------------------------------------
module xdiv_post (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  xdiv_pkg::work_t in_work,
  output logic            out_valid,
  output logic [63:0]     quotient,
  output logic [63:0]     remainder,
  output logic            divide_by_zero
);
  import xdiv_pkg::*;

  logic [WORD_W-1:0] mask, q, r, q_next, r_next;

  always_comb begin
    mask = size_mask(in_work.size);
    q    = (in_work.sa ^ in_work.sb) ? (~in_work.quo + 64'd1) : in_work.quo;
    r    = in_work.sa ? (~in_work.rem + 64'd1) : in_work.rem;
    q_next = in_work.zero ? mask : (q & mask);
    r_next = in_work.zero ? in_work.lo : (r & mask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quotient       <= q_next;
      remainder      <= r_next;
      divide_by_zero <= in_work.zero;
    end
  end

endmodule

[sv/x86_double_width_divider.sv]
// ---------------------------------------------------------------------------
// x86_double_width_divider
// Pipelined DIV / IDIV unit for 8, 16, 32 and 64-bit operand sizes.
// ---------------------------------------------------------------------------
// Usage:
//   Input beats arrive on the s_axis group: tdata carries the dividend
//   halves and the divisor, tuser the operation and the operand size.
//   Results leave on the m_axis group: tdata carries quotient and
//   remainder, tuser the divide-by-zero flag.
//   The pipeline has one preparation stage, 128 restoring division
//   stages (one dividend bit each) and one sign and size fix-up stage.
//   Throughput is one beat per cycle while the output is not stalled; each stage holds at most one beat.
//   The whole pipeline advances together whenever the output register is
//   empty or being taken, so a stalled receiver freezes every stage and
//   drops s_axis_tready in the same cycle; nothing is lost or repeated.
//   Reset clears all valid bits; the pipeline is then empty and ready.
//   A zero divisor gives all-ones quotient, the low dividend half as
//   remainder, and raises the flag; signed overflow wraps silently.
// ---------------------------------------------------------------------------
module x86_double_width_divider (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,  // dividend_low, dividend_high, divisor
  input  logic [2:0]   s_axis_tuser,  // operation, operand_size
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // quotient, remainder
  output logic         m_axis_tuser   // divide_by_zero
);
  import xdiv_pkg::*;

  logic              advance;
  logic              valid [STEPS+1];
  work_t             work  [STEPS+1];
  logic [WORD_W-1:0] quotient, remainder;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;
  assign m_axis_tdata  = {remainder, quotient};

  xdiv_prep u_prep (
    .clk           (clk),
    .rst           (rst),
    .en            (advance),
    .in_valid      (s_axis_tvalid),
    .is_signed     (s_axis_tuser[0]),
    .size          (s_axis_tuser[2:1]),
    .dividend_low  (s_axis_tdata[63:0]),
    .dividend_high (s_axis_tdata[127:64]),
    .divisor       (s_axis_tdata[191:128]),
    .out_valid     (valid[0]),
    .out_work      (work[0])
  );

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    xdiv_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .in_valid  (valid[i]),
      .in_work   (work[i]),
      .out_valid (valid[i+1]),
      .out_work  (work[i+1])
    );
  end

  xdiv_post u_post (
    .clk            (clk),
    .rst            (rst),
    .en             (advance),
    .in_valid       (valid[STEPS]),
    .in_work        (work[STEPS]),
    .out_valid      (m_axis_tvalid),
    .quotient       (quotient),
    .remainder      (remainder),
    .divide_by_zero (m_axis_tuser)
  );

endmodule

[sv/xdiv_checker.sv]
// ---------------------------------------------------------------------------
// xdiv_checker
// Port-level checks of the double-width divider, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module xdiv_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  `ASSERT_IMPLY(a_ready_follows_out, clk, rst, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
  `ASSERT_ALWAYS(a_empty_after_reset, clk, $past(rst), !m_axis_tvalid)
  `ASSERT_IMPLY(a_zero_quotient_ones, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata[7:0] == 8'hff)
  `ASSERT_NEXT(a_stall_holds, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind x86_double_width_divider xdiv_checker u_xdiv_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/tb_x86_double_width_divider.sv]
// ---------------------------------------------------------------------------
// tb_x86_double_width_divider
// Self-checking bench for the DIV / IDIV unit: directed corner beats, then
// random beats with random idling on both sides, compared with a predictor.
// ---------------------------------------------------------------------------
module tb_x86_double_width_divider;
  timeunit 1ns;
  timeprecision 1ps;
  import xdiv_pkg::*;

  typedef struct {
    logic        op;
    logic [1:0]  size;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] d;
  } div_req_t;

  typedef struct {
    logic [63:0] q;
    logic [63:0] r;
    logic        dz;
  } div_res_t;

  localparam logic OP_DIV  = 1'b0;
  localparam logic OP_IDIV = 1'b1;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata;   // dividend_low, dividend_high, divisor
  logic [2:0]   s_axis_tuser;   // operation, operand_size
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;   // quotient, remainder
  logic         m_axis_tuser;   // divide_by_zero

  div_req_t pending_reqs[$];
  div_res_t expected_results[$];
  int       errors = 0;
  bit       calm;
  bit       hold_sender;
  bit       stall_go;
  bit       sink_hold;
  int       src_gap;
  int       sink_gap;

  x86_double_width_divider u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    sink_hold = 1'b0;
    wait (stall_go);
    sink_hold <= 1'b1;
    repeat (400) @(posedge clk);
    sink_hold <= 1'b0;
  end

  function automatic logic [63:0] mask_of(logic [1:0] size);
    case (size)
      SIZE_8:  return 64'hff;
      SIZE_16: return 64'hffff;
      SIZE_32: return 64'hffff_ffff;
      default: return '1;
    endcase
  endfunction

  function automatic div_res_t predict_division(div_req_t t);
    div_res_t    res;
    logic [63:0] m;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] d;
    logic [63:0] dmag;
    logic [127:0] num;
    logic [127:0] q;
    logic [127:0] r;
    int          n;
    bit          sa;
    bit          sb;
    m  = mask_of(t.size);
    n  = 8 << t.size;
    lo = t.lo & m;
    hi = t.hi & m;
    d  = t.d & m;
    if (d == 0) begin
      res.q = m; res.r = lo; res.dz = 1'b1;
      return res;
    end
    num = (n == 64) ? {hi, lo} : (128'(hi) << n) | 128'(lo);
    sa = 0; sb = 0; dmag = d;
    if (t.op == OP_IDIV) begin
      sa = num[2*n-1];
      if (sa) begin
        if (n != 64) num = num | ~((128'd1 << (2*n)) - 1);
        num = -num;
      end
      sb = d[n-1];
      if (sb) dmag = (-d) & m;
    end
    q = num / 128'(dmag);
    r = num % 128'(dmag);
    if (sa != sb) q = -q;
    if (sa) r = -r;
    res.q = q[63:0] & m; res.r = r[63:0] & m; res.dz = 1'b0;
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_value(logic [1:0] size);
    logic [63:0] m;
    logic [63:0] v;
    m = mask_of(size);
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = m;
      2: v = 64'd1;
      3: v = m >> 1;
      4: v = (m >> 1) + 1;
      5: v = $urandom_range(0, 15);
      default: v = rand64();
    endcase
    if ($urandom_range(0, 3) == 0) v = v | (rand64() & ~m);
    return v;
  endfunction

  task automatic add_req(logic op, logic [1:0] size, logic [63:0] lo,
                         logic [63:0] hi, logic [63:0] d);
    div_req_t t;
    t.op = op; t.size = size; t.lo = lo; t.hi = hi; t.d = d;
    pending_reqs.push_back(t);
  endtask

  task automatic add_random_req();
    logic [1:0]  size;
    logic [63:0] m;
    logic [63:0] d;
    logic [63:0] hi;
    size = 2'($urandom_range(0, 3));
    m = mask_of(size);
    d = pick_value(size);
    hi = pick_value(size);
    // mostly keep the quotient in range so normal results dominate
    if ($urandom_range(0, 2) != 0 && (d & m) != 0) hi = ((hi & m) % (d & m)) | (hi & ~m);
    add_req(1'($urandom_range(0, 1)), size, pick_value(size), hi, d);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      src_gap <= 0;
    end else begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          src_gap <= $urandom_range(0, 16);
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !hold_sender) begin
          div_req_t t;
          t = pending_reqs.pop_front();
          expected_results.push_back(predict_division(t));
          s_axis_tdata  <= {t.d, t.hi, t.lo};
          s_axis_tuser  <= {t.size, t.op};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (sink_hold) begin
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        sink_gap <= $urandom_range(0, 16);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result q=%h r=%h dz=%b", $time,
                   m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tuser);
          errors++;
        end else begin
          div_res_t e;
          e = expected_results.pop_front();
          if (m_axis_tdata[63:0] !== e.q) begin
            $display("%0t: quotient expected %h actual %h", $time, e.q, m_axis_tdata[63:0]);
            errors++;
          end
          if (m_axis_tdata[127:64] !== e.r) begin
            $display("%0t: remainder expected %h actual %h", $time, e.r,
                     m_axis_tdata[127:64]);
            errors++;
          end
          if (m_axis_tuser !== e.dz) begin
            $display("%0t: divide_by_zero expected %b actual %b", $time, e.dz, m_axis_tuser);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    calm = 0; hold_sender = 0; stall_go = 0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int s = 0; s < 4; s++) begin
      add_req(OP_DIV, 2'(s), '1, '1 >> 1, '1);
      add_req(OP_DIV, 2'(s), '1, '1, 64'd0);
      add_req(OP_IDIV, 2'(s), '0, '1, '1);
      add_req(OP_IDIV, 2'(s), '1, '1, '0);
      add_req(OP_IDIV, 2'(s), 64'd7, '1, 64'd2);
    end
    add_req(OP_IDIV, SIZE_8, 64'h00, 64'h80, 64'hff);
    add_req(OP_IDIV, SIZE_16, 64'h0, 64'h8000, 64'hffff);
    add_req(OP_IDIV, SIZE_32, 64'h0, 64'h8000_0000, 64'hffff_ffff);
    add_req(OP_IDIV, SIZE_64, 64'h0, 64'h8000_0000_0000_0000, '1);
    add_req(OP_DIV, SIZE_64, '1, '1, 64'd1);
    for (int i = 0; i < 200; i++) add_random_req();
    wait (pending_reqs.size() == 0);
    // fill the pipeline while the receiver holds off
    stall_go = 1;
    for (int i = 0; i < 200; i++) add_random_req();
    wait (pending_reqs.size() == 0);
    hold_sender = 1;
    wait (expected_results.size() == 0);
    hold_sender = 0;
    for (int i = 0; i < 200; i++) add_random_req();
    wait (pending_reqs.size() == 0);
    calm = 1;
    for (int i = 0; i < 100; i++) add_random_req();
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    wait (expected_results.size() == 0);
    repeat (150) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
